// ----- sv/teg_pkg.sv -----
// ----------------------------------------------------------------------------
// Trapezoid envelope generator package
// Shared widths, register indexes, reset values and types.
// ----------------------------------------------------------------------------
package teg_pkg;

    // Fixed-point format: full scale 2^LEVEL_BITS means 1.0.
    localparam int LEVEL_BITS    = 24;
    localparam int LW            = LEVEL_BITS + 1;
    localparam int COUNT_BITS    = 20;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = LW;

    localparam logic [LW-1:0] FULL_SCALE = {1'b1, {LEVEL_BITS{1'b0}}};

    // Register reset values.
    localparam logic [LW-1:0]         ATTACK_STEP_RST = LW'(349);
    localparam logic [COUNT_BITS-1:0] ON_SAMPLES_RST  = COUNT_BITS'(48000);
    localparam logic [LW-1:0]         DECAY_STEP_RST  = LW'(23);
    localparam logic [COUNT_BITS-1:0] OFF_SAMPLES_RST = COUNT_BITS'(48000);

    // Envelope phases, encoded as they appear on the output.
    typedef enum logic [1:0] {
        PH_ATTACK = 2'd0,
        PH_ON     = 2'd1,
        PH_DECAY  = 2'd2,
        PH_OFF    = 2'd3
    } t_phase;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ATTACK_STEP = 3'd0,
        REG_ON_SAMPLES  = 3'd1,
        REG_DECAY_STEP  = 3'd2,
        REG_OFF_SAMPLES = 3'd3,
        REG_AUTO_REPEAT = 3'd4
    } t_cfg_idx;

    // Configuration register file contents.
    typedef struct packed {
        logic [LW-1:0]         attack_step;
        logic [COUNT_BITS-1:0] on_samples;
        logic [LW-1:0]         decay_step;
        logic [COUNT_BITS-1:0] off_samples;
        logic                  auto_repeat;
    } t_cfg;

    // One envelope result.
    typedef struct packed {
        logic [LW-1:0] level;
        t_phase        phase;
    } t_env;

endpackage

// ----- sv/teg_smp_if.sv -----
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel carrying the key-on pulse and gate level.
// ----------------------------------------------------------------------------
interface teg_smp_if;
    logic valid;
    logic ready;
    logic key_on;
    logic gate_high;

    modport source (output valid, output key_on, output gate_high, input ready);
    modport sink   (input valid, input key_on, input gate_high, output ready);
endinterface

// ----- sv/teg_env_if.sv -----
// ----------------------------------------------------------------------------
// Envelope output channel
// Valid/ready channel carrying the envelope level and phase.
// ----------------------------------------------------------------------------
interface teg_env_if
    import teg_pkg::*;
;
    logic          valid;
    logic          ready;
    logic [LW-1:0] level;
    logic [1:0]    phase;

    modport source (output valid, output level, output phase, input ready);
    modport sink   (input valid, input level, input phase, output ready);
endinterface

// ----- sv/teg_cfg.sv -----
// ----------------------------------------------------------------------------
// Envelope configuration registers
// Write-only register file; writes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module teg_cfg
    import teg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    // Register writes, truncated to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_step <= ATTACK_STEP_RST;
            r_cfg.on_samples  <= ON_SAMPLES_RST;
            r_cfg.decay_step  <= DECAY_STEP_RST;
            r_cfg.off_samples <= OFF_SAMPLES_RST;
            r_cfg.auto_repeat <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_ATTACK_STEP: r_cfg.attack_step <= i_cfg_data[LW-1:0];
                REG_ON_SAMPLES:  r_cfg.on_samples  <= i_cfg_data[COUNT_BITS-1:0];
                REG_DECAY_STEP:  r_cfg.decay_step  <= i_cfg_data[LW-1:0];
                REG_OFF_SAMPLES: r_cfg.off_samples <= i_cfg_data[COUNT_BITS-1:0];
                REG_AUTO_REPEAT: r_cfg.auto_repeat <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/teg_core.sv -----
// ----------------------------------------------------------------------------
// Envelope phase sequencer
// Applies key-on and gate edge, then advances the level and hold counter
// by one sample for every accepted input transfer.
// ----------------------------------------------------------------------------
module teg_core
    import teg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_acc,
    input  logic i_key_on,
    input  logic i_gate_high,
    output t_env o_env
);

    t_phase                r_phase, n_phase;
    logic [LW-1:0]         r_level, n_level;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                  r_armed, n_armed;

    t_phase                cur_phase;
    logic [LW-1:0]         cur_level;
    logic [LW:0]           att_sum;
    logic [COUNT_BITS-1:0] cnt_dec;

    // Key-on and gate edge take effect before the sample is produced.
    always_comb begin
        cur_phase = r_phase;
        cur_level = r_level;
        n_armed   = r_armed;
        if (i_key_on) begin
            cur_level = '0;
            cur_phase = PH_ATTACK;
        end
        if (!r_armed) begin
            if (i_gate_high) begin
                cur_phase = PH_ATTACK;
                n_armed   = 1'b1;
            end
        end else if (!i_gate_high) begin
            n_armed = 1'b0;
        end
    end

    assign att_sum = {1'b0, cur_level} + {1'b0, i_cfg.attack_step};
    assign cnt_dec = (r_cnt != '0) ? r_cnt - 1'b1 : r_cnt;

    // Next state: level ramp, hold countdown and phase change.
    always_comb begin
        n_phase = cur_phase;
        n_level = cur_level;
        n_cnt   = r_cnt;
        unique case (cur_phase)
            PH_ATTACK: begin
                if (att_sum >= {1'b0, FULL_SCALE}) begin
                    n_level = FULL_SCALE;
                    n_phase = PH_ON;
                    n_cnt   = i_cfg.on_samples;
                end else begin
                    n_level = att_sum[LW-1:0];
                end
            end
            PH_ON: begin
                n_cnt = cnt_dec;
                if (cnt_dec == '0) begin
                    n_phase = PH_DECAY;
                end
            end
            PH_DECAY: begin
                if (cur_level > i_cfg.decay_step) begin
                    n_level = cur_level - i_cfg.decay_step;
                end else begin
                    n_level = '0;
                    n_phase = PH_OFF;
                    n_cnt   = i_cfg.off_samples;
                end
            end
            PH_OFF: begin
                n_cnt = cnt_dec;
                if (cnt_dec == '0 && i_cfg.auto_repeat) begin
                    n_phase = PH_ATTACK;
                end
            end
            default: ;
        endcase
    end

    // Outputs: the sample emitted in the phase it was produced in.
    always_comb begin
        o_env.phase = cur_phase;
        unique case (cur_phase)
            PH_ATTACK, PH_DECAY: o_env.level = n_level;
            PH_ON:               o_env.level = FULL_SCALE;
            default:             o_env.level = '0;
        endcase
    end

    // State registers advance once per accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OFF;
            r_level <= '0;
            r_cnt   <= '0;
            r_armed <= 1'b0;
        end else if (i_acc) begin
            r_phase <= n_phase;
            r_level <= n_level;
            r_cnt   <= n_cnt;
            r_armed <= n_armed;
        end
    end

endmodule

// ----- sv/teg_oreg.sv -----
// ----------------------------------------------------------------------------
// Envelope output register with skid stage
// Holds results until transferred; the skid entry lets the input take one
// more transfer while the output is stalled.
// ----------------------------------------------------------------------------
module teg_oreg
    import teg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_acc,
    input  t_env i_env,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_env o_env,
    output logic o_skid_valid
);

    logic r_out_v, r_skid_v;
    t_env r_out, r_skid;
    logic out_xfer;

    assign out_xfer = r_out_v && i_out_ready;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_xfer) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_acc;
            end
        end else if (i_acc) begin
            if (r_out_v) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_out <= r_skid_v ? r_skid : i_env;
        end else if (i_acc) begin
            if (r_out_v) begin
                r_skid <= i_env;
            end else begin
                r_out <= i_env;
            end
        end
    end

    assign o_in_ready   = !r_skid_v;
    assign o_out_valid  = r_out_v;
    assign o_env        = r_out;
    assign o_skid_valid = r_skid_v;

endmodule

// ----- sv/trapezoid_envelope_generator.sv -----
// Each result is registered in the output register, or in the skid entry behind it.
// Throughput: one sample per cycle while the output accepts; the level add/compare
// and the hold counter decrement both finish within the cycle of the input transfer.
// A one-entry skid stage takes one more input transfer while the output is stalled.
// Reset (synchronous, active low) restores register defaults, off phase,
// zero level, zero hold count and a disarmed gate.
// ----------------------------------------------------------------------------
// Trapezoid envelope generator
// Attack, on, decay and off phases, one envelope level per audio sample.
// ----------------------------------------------------------------------------
module trapezoid_envelope_generator
    import teg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    teg_smp_if.sink                  i_smp,
    teg_env_if.source                o_env
);

    t_cfg cfg;
    t_env core_env;
    t_env out_env;
    logic in_ready;
    logic acc;
    logic skid_v;

    assign acc         = i_smp.valid && in_ready;
    assign i_smp.ready = in_ready;

    // Configuration registers.
    teg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Phase sequencer.
    teg_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_acc       (acc),
        .i_key_on    (i_smp.key_on),
        .i_gate_high (i_smp.gate_high),
        .o_env       (core_env)
    );

    // Result register and skid stage.
    teg_oreg u_oreg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_env        (core_env),
        .i_out_ready  (o_env.ready),
        .o_in_ready   (in_ready),
        .o_out_valid  (o_env.valid),
        .o_env        (out_env),
        .o_skid_valid (skid_v)
    );

    assign o_env.level = out_env.level;
    assign o_env.phase = out_env.phase;

`ifndef SYNTHESIS
    // The level never exceeds full scale.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_env.valid |-> (o_env.level <= FULL_SCALE))
        else $error("envelope level above full scale");

    // The on phase always emits full scale and the off phase always zero.
    a_hold_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_env.valid |-> ((o_env.phase != PH_ON || o_env.level == FULL_SCALE)
                      && (o_env.phase != PH_OFF || o_env.level == '0)))
        else $error("hold phase with wrong level");

    // The skid entry is only occupied behind a full output register.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skid_v |-> o_env.valid)
        else $error("skid entry valid with empty output register");

    // An input transfer during an output stall is captured in the skid entry.
    a_skid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_env.valid && !o_env.ready && i_smp.valid && i_smp.ready) |=> skid_v)
        else $error("input transfer during stall not captured in skid entry");
`endif

endmodule

// ----- sim/envelope_checker.sv -----
// ----------------------------------------------------------------------------
// Envelope checker
// Watches the configuration port and both channels, tracks the envelope
// state for every accepted sample and compares each result transfer with
// the oldest predicted envelope level and phase.
// ----------------------------------------------------------------------------
module envelope_checker
    import teg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    teg_smp_if                       i_smp,
    teg_env_if                       i_env,
    output int unsigned              o_fail_count,
    output int unsigned              o_pending
);

    // Register copy and envelope state as the block should hold them.
    t_cfg                  env_regs;
    t_phase                env_phase;
    logic [LW-1:0]         env_level;
    logic [COUNT_BITS-1:0] hold_left;
    logic                  gate_armed;

    // Predicted results, oldest first.
    t_env                  expected_env[$];

    // Advance the envelope by one sample and return what it emits.
    // Key-on is applied first, then the gate edge, then the sample itself.
    task automatic advance_envelope(input logic key, input logic gate, output t_env result);
        t_phase        emitted;
        logic [LW-1:0] out_level;
        emitted   = env_phase;
        out_level = '0;
        if (key) begin
            env_level = '0;
            env_phase = PH_ATTACK;
        end
        if (!gate_armed) begin
            if (gate) begin
                env_phase  = PH_ATTACK;
                gate_armed = 1'b1;
            end
        end else if (!gate) begin
            gate_armed = 1'b0;
        end

        emitted = env_phase;
        case (env_phase)
            PH_ATTACK: begin
                // Clamp at full scale; the sample that gets there ends attack.
                if (env_regs.attack_step >= FULL_SCALE - env_level) begin
                    env_level = FULL_SCALE;
                end else begin
                    env_level = env_level + env_regs.attack_step;
                end
                out_level = env_level;
                if (env_level == FULL_SCALE) begin
                    env_phase = PH_ON;
                    hold_left = env_regs.on_samples;
                end
            end
            PH_ON: begin
                out_level = FULL_SCALE;
                if (hold_left != '0) hold_left = hold_left - 1'b1;
                if (hold_left == '0) env_phase = PH_DECAY;
            end
            PH_DECAY: begin
                // Clamp at zero; the sample that gets there ends decay.
                if (env_level > env_regs.decay_step) begin
                    env_level = env_level - env_regs.decay_step;
                end else begin
                    env_level = '0;
                end
                out_level = env_level;
                if (env_level == '0) begin
                    env_phase = PH_OFF;
                    hold_left = env_regs.off_samples;
                end
            end
            default: begin
                out_level = '0;
                if (hold_left != '0) hold_left = hold_left - 1'b1;
                if (hold_left == '0 && env_regs.auto_repeat) env_phase = PH_ATTACK;
            end
        endcase

        result.level = out_level;
        result.phase = emitted;
    endtask

    // Track writes, check result transfers, then predict for input transfers.
    always @(posedge i_clk) begin
        t_env want;
        t_env got;
        if (!i_rst_n) begin
            env_regs.attack_step = ATTACK_STEP_RST;
            env_regs.on_samples  = ON_SAMPLES_RST;
            env_regs.decay_step  = DECAY_STEP_RST;
            env_regs.off_samples = OFF_SAMPLES_RST;
            env_regs.auto_repeat = 1'b1;
            env_phase            = PH_OFF;
            env_level            = '0;
            hold_left            = '0;
            gate_armed           = 1'b0;
            expected_env.delete();
            o_fail_count         = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ATTACK_STEP: env_regs.attack_step = i_cfg_data;
                    REG_ON_SAMPLES:  env_regs.on_samples  = i_cfg_data[COUNT_BITS-1:0];
                    REG_DECAY_STEP:  env_regs.decay_step  = i_cfg_data;
                    REG_OFF_SAMPLES: env_regs.off_samples = i_cfg_data[COUNT_BITS-1:0];
                    REG_AUTO_REPEAT: env_regs.auto_repeat = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_env.valid && i_env.ready) begin
                if (expected_env.size() == 0) begin
                    $error("unexpected envelope transfer: level %0d phase %0d",
                           i_env.level, i_env.phase);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_env.pop_front();
                    if (i_env.level !== want.level) begin
                        $error("level: expected %0d, actual %0d", want.level, i_env.level);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_env.phase !== want.phase) begin
                        $error("phase: expected %0d, actual %0d", want.phase, i_env.phase);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end

            if (i_smp.valid && i_smp.ready) begin
                advance_envelope(i_smp.key_on, i_smp.gate_high, got);
                expected_env.push_back(got);
            end
        end
        o_pending <= expected_env.size();
    end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Envelope generator testbench
// Drives samples and register settings into the envelope generator with
// random stalls on both channels; the checker beside the block predicts
// every envelope level and phase and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import teg_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned PHASE_COUNT      = 9;
    localparam int unsigned ITEMS_PER_PHASE  = 90;
    localparam int unsigned LONG_HOLD_AT     = 400;
    localparam int unsigned LONG_HOLD_CYCLES = 120;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int unsigned              fail_count;
    int unsigned              pending;
    int unsigned              cycles = 0;
    bit                       steady = 1'b0;
    logic                     gate_level;

    teg_smp_if smp_ch ();
    teg_env_if env_ch ();

    trapezoid_envelope_generator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_smp      (smp_ch),
        .o_env      (env_ch)
    );

    envelope_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_smp        (smp_ch),
        .i_env        (env_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random ready bursts, one long hold-off once the run is
    // well underway so the block backs up, and no stalls in the last phase.
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned run_left;
        int unsigned taken;
        bit          held_long;
        stall_left = 0;
        run_left   = 0;
        taken      = 0;
        held_long  = 1'b0;
        env_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (env_ch.valid && env_ch.ready) taken++;
            if (!held_long && taken >= LONG_HOLD_AT) begin
                held_long  = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left != 0) begin
                env_ch.ready <= 1'b0;
                stall_left--;
            end else if (steady) begin
                env_ch.ready <= 1'b1;
            end else if (run_left != 0) begin
                env_ch.ready <= 1'b1;
                run_left--;
            end else if ($urandom_range(0, 1) == 0) begin
                env_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                env_ch.ready <= 1'b1;
                run_left = $urandom_range(0, 40);
            end
        end
    end

    // Offer one sample, after an occasional gap, and hold it until the transfer.
    task automatic send_sample(input logic key, input logic gate);
        if (!steady && $urandom_range(0, 3) == 0) begin
            smp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        smp_ch.valid     <= 1'b1;
        smp_ch.key_on    <= key;
        smp_ch.gate_high <= gate;
        do @(posedge i_clk); while (!smp_ch.ready);
    endtask

    // Stop offering samples until every predicted result has come out.
    task automatic drain_results;
        smp_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // One register write; the caller lowers the enable after the last one.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
    endtask

    // Write all five registers plus one index past the end of the map,
    // which the block must ignore.
    task automatic program_envelope(input logic [CFG_DATA_BITS-1:0] attack,
                                    input logic [CFG_DATA_BITS-1:0] on_len,
                                    input logic [CFG_DATA_BITS-1:0] decay,
                                    input logic [CFG_DATA_BITS-1:0] off_len,
                                    input logic [CFG_DATA_BITS-1:0] repeat_on);
        write_reg(REG_ATTACK_STEP, attack);
        write_reg(REG_ON_SAMPLES, on_len);
        write_reg(REG_DECAY_STEP, decay);
        write_reg(REG_OFF_SAMPLES, off_len);
        write_reg(REG_AUTO_REPEAT, repeat_on);
        write_reg(CFG_IDX_BITS'(REG_AUTO_REPEAT + $urandom_range(1, 3)),
                  CFG_DATA_BITS'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Level step: mostly a few samples per ramp, sometimes an extreme.
    function automatic logic [CFG_DATA_BITS-1:0] pick_step();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return CFG_DATA_BITS'(1);
            2:       return FULL_SCALE;
            3:       return '1;
            default: return CFG_DATA_BITS'(FULL_SCALE / $urandom_range(1, 24)
                                           + $urandom_range(0, 255));
        endcase
    endfunction

    // Hold count with junk above the count width, which must be dropped.
    function automatic logic [CFG_DATA_BITS-1:0] pick_count();
        logic [COUNT_BITS-1:0] count;
        case ($urandom_range(0, 9))
            0:       count = '0;
            1:       count = '1;
            default: count = COUNT_BITS'($urandom_range(1, 24));
        endcase
        return CFG_DATA_BITS'({$urandom, count});
    endfunction

    // Settings per random phase: fixed extremes first, then random mixes.
    task automatic configure_phase(input int unsigned phase_no);
        case (phase_no)
            0: program_envelope('1, '0, '1, '0, CFG_DATA_BITS'(1));
            1: program_envelope(CFG_DATA_BITS'(1), CFG_DATA_BITS'({COUNT_BITS{1'b1}}),
                                CFG_DATA_BITS'(1), CFG_DATA_BITS'({COUNT_BITS{1'b1}}),
                                '0);
            2: program_envelope(FULL_SCALE, CFG_DATA_BITS'(1), '0,
                                CFG_DATA_BITS'(1), CFG_DATA_BITS'(1));
            3: program_envelope('0, CFG_DATA_BITS'(2), FULL_SCALE,
                                CFG_DATA_BITS'(2), CFG_DATA_BITS'(1));
            default: program_envelope(pick_step(), pick_count(), pick_step(), pick_count(),
                                      CFG_DATA_BITS'($urandom));
        endcase
    endtask

    // Stimulus and verdict.
    initial begin : stimulus
        logic key;
        logic gate;
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= REG_ATTACK_STEP;
        cfg_data         <= '0;
        smp_ch.valid     <= 1'b0;
        smp_ch.key_on    <= 1'b0;
        smp_ch.gate_high <= 1'b0;
        gate_level = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: leave off at once, then key-on, a gate rising
        // edge without zeroing, a held gate and its release.
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);

        // Short ramps so the attack, on and decay phases and the attack clamp
        // show up within a few samples; key-on lands in the on phase, the gate
        // edge in decay, and at the end key-on and a gate edge arrive together.
        drain_results();
        program_envelope(FULL_SCALE >> 1, CFG_DATA_BITS'(2), CFG_DATA_BITS'(FULL_SCALE / 3),
                         CFG_DATA_BITS'(1), CFG_DATA_BITS'(1));
        for (int i = 0; i < 16; i++) begin
            key  = (i == 3) || (i == 13);
            gate = (i >= 8 && i <= 10) || (i == 13);
            send_sample(key, gate);
        end

        // Random phases: mostly clean key-on pulses and gate levels with
        // occasional random noise on both bits.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_results();
            configure_phase(p);
            steady = (p == PHASE_COUNT - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 4 && n == ITEMS_PER_PHASE / 2) drain_results();
                if ($urandom_range(0, 9) == 0) begin
                    key  = 1'($urandom);
                    gate = 1'($urandom);
                end else begin
                    key = ($urandom_range(0, 29) == 0);
                    if ($urandom_range(0, 7) == 0) gate_level = ~gate_level;
                    gate = gate_level;
                end
                send_sample(key, gate);
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
